// ===== hw/rtl/tcsf_pkg.sv =====
// Package for the three-channel spike filter: field widths, fixed limits,
// register indexes, reset values and status codes.
// No dependencies.
package tcsf_pkg;

    localparam int TEMP_W  = 15;
    localparam int HUM_W   = 14;
    localparam int PRESS_W = 17;
    localparam int CNT_W   = 16;

    // common width of the per-channel check datapath (signed)
    localparam int CHK_W   = 18;
    localparam int STEP_W  = CHK_W - 1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [HUM_W-1:0] HUM_MAX = 14'd10000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TEMP_MIN   = 3'd0,
        REG_TEMP_MAX   = 3'd1,
        REG_PRESS_MIN  = 3'd2,
        REG_PRESS_MAX  = 3'd3,
        REG_TEMP_STEP  = 3'd4,
        REG_HUM_STEP   = 3'd5,
        REG_PRESS_STEP = 3'd6
    } cfg_reg_t;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN_RST   = -15'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX_RST   = 15'sd6000;
    localparam logic [PRESS_W-1:0]       PRESS_MIN_RST  = 17'd85000;
    localparam logic [PRESS_W-1:0]       PRESS_MAX_RST  = 17'd110000;
    localparam logic [TEMP_W-1:0]        TEMP_STEP_RST  = 15'd300;
    localparam logic [HUM_W-1:0]         HUM_STEP_RST   = 14'd1500;
    localparam logic [PRESS_W-1:0]       PRESS_STEP_RST = 17'd200;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FAIL   = 2'd1,
        STATUS_REJECT = 2'd2
    } status_t;

endpackage

// ===== hw/rtl/three_channel_spike_filter_core.sv =====
// Top level of the three-channel spike filter: stream ports, configuration
// registers, history state and the result register. Uses tcsf_pkg and
// tcsf_chan_check.
//
// One sample set per transaction, one result per transaction. A set is
// captured in an input register, checked combinationally against the limits and
// the last good values, and written to the result register while the history
// updates for the next set, so a new set can be taken every cycle while the
// result stream is not stalled. Configuration writes take effect on the
// next cycle and should be made only while no set is in flight.
module three_channel_spike_filter_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,  // temp_sample, hum_sample,
                                                          // press_sample, zero pad
    input  logic [3:0]                          s_tuser,  // temp_bad, hum_bad,
                                                          // press_bad, measure_ok
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [63:0]                         m_tdata,  // temp_out, hum_out,
                                                          // press_out, reject_total, pad
    output logic [4:0]                          m_tuser,  // status[1:0], temp_held,
                                                          // hum_held, press_held
    // configuration write port
    input  logic                                cfg_we,
    input  logic [tcsf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tcsf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import tcsf_pkg::*;

    // configuration
    logic signed [TEMP_W-1:0] temp_min_reg, temp_max_reg;
    logic [PRESS_W-1:0]       press_min_reg, press_max_reg;
    logic [TEMP_W-1:0]        temp_step_reg;
    logic [HUM_W-1:0]         hum_step_reg;
    logic [PRESS_W-1:0]       press_step_reg;

    // history
    logic signed [TEMP_W-1:0] last_temp_reg, last_temp_next;
    logic [HUM_W-1:0]         last_hum_reg, last_hum_next;
    logic [PRESS_W-1:0]       last_press_reg, last_press_next;
    logic                     hist_valid_reg, hist_valid_next;
    logic [CNT_W-1:0]         rej_cnt_reg, rej_cnt_next;

    // input register
    logic                     in_valid_reg;
    logic signed [TEMP_W-1:0] in_temp_reg;
    logic [HUM_W-1:0]         in_hum_reg;
    logic [PRESS_W-1:0]       in_press_reg;
    logic [3:0]               in_flags_reg;

    // result register
    logic                     out_valid_reg;
    logic [TEMP_W-1:0]        out_temp_reg, out_temp_next;
    logic [HUM_W-1:0]         out_hum_reg, out_hum_next;
    logic [PRESS_W-1:0]       out_press_reg, out_press_next;
    status_t                  out_status_reg, out_status_next;
    logic [2:0]               out_held_reg, out_held_next;
    logic [CNT_W-1:0]         out_rej_reg;

    logic advance;
    logic good_t, good_h, good_p;
    logic meas_ok;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign meas_ok  = in_flags_reg[3];

    tcsf_chan_check u_chk_temp (
        .bad        (in_flags_reg[0]),
        .cur        ({{(CHK_W-TEMP_W){in_temp_reg[TEMP_W-1]}}, in_temp_reg}),
        .lo         ({{(CHK_W-TEMP_W){temp_min_reg[TEMP_W-1]}}, temp_min_reg}),
        .hi         ({{(CHK_W-TEMP_W){temp_max_reg[TEMP_W-1]}}, temp_max_reg}),
        .prev       ({{(CHK_W-TEMP_W){last_temp_reg[TEMP_W-1]}}, last_temp_reg}),
        .step       ({{(STEP_W-TEMP_W){1'b0}}, temp_step_reg}),
        .hist_valid (hist_valid_reg),
        .good       (good_t)
    );

    tcsf_chan_check u_chk_hum (
        .bad        (in_flags_reg[1]),
        .cur        ({{(CHK_W-HUM_W){1'b0}}, in_hum_reg}),
        .lo         ({CHK_W{1'b0}}),
        .hi         ({{(CHK_W-HUM_W){1'b0}}, HUM_MAX}),
        .prev       ({{(CHK_W-HUM_W){1'b0}}, last_hum_reg}),
        .step       ({{(STEP_W-HUM_W){1'b0}}, hum_step_reg}),
        .hist_valid (hist_valid_reg),
        .good       (good_h)
    );

    tcsf_chan_check u_chk_press (
        .bad        (in_flags_reg[2]),
        .cur        ({{(CHK_W-PRESS_W){1'b0}}, in_press_reg}),
        .lo         ({{(CHK_W-PRESS_W){1'b0}}, press_min_reg}),
        .hi         ({{(CHK_W-PRESS_W){1'b0}}, press_max_reg}),
        .prev       ({{(CHK_W-PRESS_W){1'b0}}, last_press_reg}),
        .step       (press_step_reg),
        .hist_valid (hist_valid_reg),
        .good       (good_p)
    );

    always_comb begin
        last_temp_next  = last_temp_reg;
        last_hum_next   = last_hum_reg;
        last_press_next = last_press_reg;
        hist_valid_next = hist_valid_reg;
        rej_cnt_next    = rej_cnt_reg;
        out_temp_next   = '0;
        out_hum_next    = '0;
        out_press_next  = '0;
        out_held_next   = '0;
        out_status_next = STATUS_OK;
        if (!meas_ok) begin
            out_status_next = STATUS_FAIL;
        end else if (!hist_valid_reg && !(good_t && good_h && good_p)) begin
            out_status_next = STATUS_REJECT;
            if (rej_cnt_reg != {CNT_W{1'b1}}) begin
                rej_cnt_next = rej_cnt_reg + 1'b1;
            end
        end else begin
            out_temp_next  = good_t ? in_temp_reg  : last_temp_reg;
            out_hum_next   = good_h ? in_hum_reg   : last_hum_reg;
            out_press_next = good_p ? in_press_reg : last_press_reg;
            out_held_next  = {!good_p, !good_h, !good_t};
            if (good_t) last_temp_next  = in_temp_reg;
            if (good_h) last_hum_next   = in_hum_reg;
            if (good_p) last_press_next = in_press_reg;
            hist_valid_next = 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_min_reg   <= TEMP_MIN_RST;
            temp_max_reg   <= TEMP_MAX_RST;
            press_min_reg  <= PRESS_MIN_RST;
            press_max_reg  <= PRESS_MAX_RST;
            temp_step_reg  <= TEMP_STEP_RST;
            hum_step_reg   <= HUM_STEP_RST;
            press_step_reg <= PRESS_STEP_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TEMP_MIN:   temp_min_reg   <= cfg_wdata[TEMP_W-1:0];
                REG_TEMP_MAX:   temp_max_reg   <= cfg_wdata[TEMP_W-1:0];
                REG_PRESS_MIN:  press_min_reg  <= cfg_wdata[PRESS_W-1:0];
                REG_PRESS_MAX:  press_max_reg  <= cfg_wdata[PRESS_W-1:0];
                REG_TEMP_STEP:  temp_step_reg  <= cfg_wdata[TEMP_W-1:0];
                REG_HUM_STEP:   hum_step_reg   <= cfg_wdata[HUM_W-1:0];
                REG_PRESS_STEP: press_step_reg <= cfg_wdata[PRESS_W-1:0];
                default: ;
            endcase
        end
    end

    // control state and history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_temp_reg  <= '0;
            last_hum_reg   <= '0;
            last_press_reg <= '0;
            hist_valid_reg <= 1'b0;
            rej_cnt_reg    <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                last_temp_reg  <= last_temp_next;
                last_hum_reg   <= last_hum_next;
                last_press_reg <= last_press_next;
                hist_valid_reg <= hist_valid_next;
                rej_cnt_reg    <= rej_cnt_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_temp_reg  <= s_tdata[TEMP_W-1:0];
            in_hum_reg   <= s_tdata[TEMP_W+HUM_W-1:TEMP_W];
            in_press_reg <= s_tdata[TEMP_W+HUM_W+PRESS_W-1:TEMP_W+HUM_W];
            in_flags_reg <= s_tuser;
        end
        if (advance) begin
            out_temp_reg   <= out_temp_next;
            out_hum_reg    <= out_hum_next;
            out_press_reg  <= out_press_next;
            out_status_reg <= out_status_next;
            out_held_reg   <= out_held_next;
            out_rej_reg    <= rej_cnt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_rej_reg, out_press_reg, out_hum_reg, out_temp_reg};
    assign m_tuser  = {out_held_reg, out_status_reg};

endmodule

// ===== hw/rtl/tcsf_chan_check.sv =====
// Per-channel validity check: not-a-number flag, absolute range and
// step from the last good value. Uses tcsf_pkg.
module tcsf_chan_check (
    input  logic                               bad,
    input  logic signed [tcsf_pkg::CHK_W-1:0]  cur,
    input  logic signed [tcsf_pkg::CHK_W-1:0]  lo,
    input  logic signed [tcsf_pkg::CHK_W-1:0]  hi,
    input  logic signed [tcsf_pkg::CHK_W-1:0]  prev,
    input  logic        [tcsf_pkg::STEP_W-1:0] step,
    input  logic                               hist_valid,
    output logic                               good
);
    import tcsf_pkg::*;

    logic signed [CHK_W:0] diff;
    logic        [CHK_W:0] mag;
    logic                  in_range;
    logic                  step_ok;

    always_comb begin
        diff     = {cur[CHK_W-1], cur} - {prev[CHK_W-1], prev};
        mag      = diff[CHK_W] ? $unsigned(-diff) : $unsigned(diff);
        in_range = (cur >= lo) && (cur <= hi);
        step_ok  = !hist_valid || (mag <= {2'b00, step});
        good     = !bad && in_range && step_ok;
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for three_channel_spike_filter_core: stream driver and
// monitor with random gaps and stalls, a behavioral model of the filter, config phases.
// Depends on tcsf_pkg and the core RTL.
module testbench;
    import tcsf_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;  // decoded by nothing
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REJECT_SAT = 65535;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     temp_bad;
        logic [HUM_W-1:0]         hum;
        logic                     hum_bad;
        logic [PRESS_W-1:0]       press;
        logic                     press_bad;
        logic                     meas_ok;
    } sample_set_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
        logic [PRESS_W-1:0]       press;
        status_t                  status;
        logic                     temp_held;
        logic                     hum_held;
        logic                     press_held;
        logic [CNT_W-1:0]         rejects;
    } filtered_set_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata = '0;
    logic [3:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [63:0]           m_tdata;
    logic [4:0]            m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    three_channel_spike_filter_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // filter model: limits and history
    int lim_temp_min = int'(TEMP_MIN_RST);
    int lim_temp_max = int'(TEMP_MAX_RST);
    int lim_press_min = int'(PRESS_MIN_RST);
    int lim_press_max = int'(PRESS_MAX_RST);
    int step_temp = int'(TEMP_STEP_RST);
    int step_hum = int'(HUM_STEP_RST);
    int step_press = int'(PRESS_STEP_RST);
    int hist_temp = 0;
    int hist_hum = 0;
    int hist_press = 0;
    bit hist_valid = 1'b0;
    int reject_cnt = 0;

    sample_set_t   pending_sets[$];
    filtered_set_t expected_results[$];
    sample_set_t   cur_set;
    filtered_set_t got_res, want_res;

    bit idling_on = 1'b1;
    int in_gap = 0, in_calm = 0, out_stall = 0, out_calm = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit chan_pass(bit bad, int cur, int lo, int hi, int step, int prev);
        int d;
        if (bad || cur < lo || cur > hi)
            return 1'b0;
        if (hist_valid) begin
            d = cur - prev;
            if (d < 0)
                d = -d;
            if (d > step)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic filtered_set_t filter_set(sample_set_t s);
        filtered_set_t r;
        bit gt, gh, gp;
        int t;
        r = '0;
        t = int'($signed(s.temp));
        if (!s.meas_ok) begin
            r.status = STATUS_FAIL;
            r.rejects = CNT_W'(reject_cnt);
            return r;
        end
        gt = chan_pass(s.temp_bad, t, lim_temp_min, lim_temp_max, step_temp, hist_temp);
        gh = chan_pass(s.hum_bad, int'(s.hum), 0, int'(HUM_MAX), step_hum, hist_hum);
        gp = chan_pass(s.press_bad, int'(s.press), lim_press_min, lim_press_max,
                       step_press, hist_press);
        if (!hist_valid && !(gt && gh && gp)) begin
            if (reject_cnt < REJECT_SAT)
                reject_cnt++;
            r.status = STATUS_REJECT;
            r.rejects = CNT_W'(reject_cnt);
            return r;
        end
        r.temp = gt ? s.temp : TEMP_W'(hist_temp);
        r.hum = gh ? s.hum : HUM_W'(hist_hum);
        r.press = gp ? s.press : PRESS_W'(hist_press);
        r.status = STATUS_OK;
        r.temp_held = !gt;
        r.hum_held = !gh;
        r.press_held = !gp;
        r.rejects = CNT_W'(reject_cnt);
        if (gt)
            hist_temp = t;
        if (gh)
            hist_hum = int'(s.hum);
        if (gp)
            hist_press = int'(s.press);
        hist_valid = 1'b1;
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 1;
        if (r < 90)
            return $urandom_range(2, 4);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_set(int t, bit tb, int h, bit hb, int p, bit pb, bit ok);
        sample_set_t s;
        s.temp = TEMP_W'(t);
        s.temp_bad = tb;
        s.hum = HUM_W'(h);
        s.hum_bad = hb;
        s.press = PRESS_W'(p);
        s.press_bad = pb;
        s.meas_ok = ok;
        pending_sets.push_back(s);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int v);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'(v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= w;
        case (idx)
            REG_TEMP_MIN:   lim_temp_min = int'($signed(w[TEMP_W-1:0]));
            REG_TEMP_MAX:   lim_temp_max = int'($signed(w[TEMP_W-1:0]));
            REG_PRESS_MIN:  lim_press_min = int'(w);
            REG_PRESS_MAX:  lim_press_max = int'(w);
            REG_TEMP_STEP:  step_temp = int'(w[TEMP_W-1:0]);
            REG_HUM_STEP:   step_hum = int'(w[HUM_W-1:0]);
            REG_PRESS_STEP: step_press = int'(w);
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_sets.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // mostly within one step of the last good value, some spikes, some anywhere
    function automatic int pick_value(int anchor, int lo, int hi, int step, int fmin, int fmax);
        int a, b, r, d, v;
        r = $urandom_range(0, 99);
        a = anchor - step;
        a = (a < lo) ? lo : a;
        a = (a < fmin) ? fmin : a;
        b = anchor + step;
        b = (b > hi) ? hi : b;
        b = (b > fmax) ? fmax : b;
        if (r < 70 && a <= b) begin
            if (r < 8)
                return a;
            if (r < 16)
                return b;
            return a + int'($urandom_range(0, b - a));
        end
        if (r < 85) begin
            d = step + 1 + int'($urandom_range(0, 63));
            v = $urandom_range(0, 1) ? anchor + d : anchor - d;
            v = (v < fmin) ? fmin : v;
            return (v > fmax) ? fmax : v;
        end
        return fmin + int'($urandom_range(0, fmax - fmin));
    endfunction

    // history is valid here, so the anchors follow the model's last good values exactly
    task automatic gen_random(int n);
        int an_t, an_h, an_p, vt, vh, vp;
        bit tb, hb, pb, ok;
        an_t = hist_temp;
        an_h = hist_hum;
        an_p = hist_press;
        repeat (n) begin
            ok = $urandom_range(0, 99) >= 8;
            tb = $urandom_range(0, 99) < 6;
            hb = $urandom_range(0, 99) < 6;
            pb = $urandom_range(0, 99) < 6;
            vt = pick_value(an_t, lim_temp_min, lim_temp_max, step_temp, -16384, 16383);
            vh = pick_value(an_h, 0, int'(HUM_MAX), step_hum, 0, 16383);
            vp = pick_value(an_p, lim_press_min, lim_press_max, step_press, 0, 131071);
            if (ok && chan_pass(tb, vt, lim_temp_min, lim_temp_max, step_temp, an_t))
                an_t = vt;
            if (ok && chan_pass(hb, vh, 0, int'(HUM_MAX), step_hum, an_h))
                an_h = vh;
            if (ok && chan_pass(pb, vp, lim_press_min, lim_press_max, step_press, an_p))
                an_p = vp;
            push_set(vt, tb, vh, hb, vp, pb, ok);
        end
    endtask

    task automatic random_limits();
        int tmin, tmax, pmin, pmax;
        tmin = -int'($urandom_range(0, 16384));
        tmax = $urandom_range(0, 16383);
        pmin = $urandom_range(0, 100000);
        pmax = $urandom_range(pmin, 131071);
        // upper data bits beyond a 15-bit register are junk
        write_reg(REG_TEMP_MIN, (tmin & 32'h7FFF) | ($urandom_range(0, 3) << 15));
        write_reg(REG_TEMP_MAX, (tmax & 32'h7FFF) | ($urandom_range(0, 3) << 15));
        write_reg(REG_PRESS_MIN, pmin);
        write_reg(REG_PRESS_MAX, pmax);
        write_reg(REG_TEMP_STEP, $urandom_range(0, 3) ? $urandom_range(0, 2000)
                                                      : $urandom_range(0, 131071));
        write_reg(REG_HUM_STEP, $urandom_range(0, 3) ? $urandom_range(0, 2000)
                                                     : $urandom_range(0, 131071));
        write_reg(REG_PRESS_STEP, $urandom_range(0, 3) ? $urandom_range(0, 2000)
                                                       : $urandom_range(0, 131071));
        end_writes();
    endtask

    // input driver: prediction is made on every accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(filter_set(cur_set));
            if (!s_tvalid || s_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_sets.size() > 0) begin
                    cur_set = pending_sets.pop_front();
                    s_tdata <= {2'b00, cur_set.press, cur_set.hum, cur_set.temp};
                    s_tuser <= {cur_set.meas_ok, cur_set.press_bad, cur_set.hum_bad,
                                cur_set.temp_bad};
                    s_tvalid <= 1'b1;
                    if (!idling_on) begin
                        in_gap = 0;
                    end else if (in_calm > 0) begin
                        in_calm--;
                        in_gap = 0;
                    end else begin
                        if ($urandom_range(0, 39) == 0)
                            in_calm = $urandom_range(20, 80);
                        in_gap = $urandom_range(0, 1) ? gap_len() : 0;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_res.temp = m_tdata[14:0];
                got_res.hum = m_tdata[28:15];
                got_res.press = m_tdata[45:29];
                got_res.rejects = m_tdata[61:46];
                got_res.status = status_t'(m_tuser[1:0]);
                got_res.temp_held = m_tuser[2];
                got_res.hum_held = m_tuser[3];
                got_res.press_held = m_tuser[4];
                if (expected_results.size() == 0) begin
                    $error("result transaction with no sample set pending");
                    mismatches++;
                end else begin
                    want_res = expected_results.pop_front();
                    check_field("temp_out", int'($signed(want_res.temp)),
                                int'($signed(got_res.temp)));
                    check_field("hum_out", int'(want_res.hum), int'(got_res.hum));
                    check_field("press_out", int'(want_res.press), int'(got_res.press));
                    check_field("status", int'(want_res.status), int'(got_res.status));
                    check_field("temp_held", want_res.temp_held, got_res.temp_held);
                    check_field("hum_held", want_res.hum_held, got_res.hum_held);
                    check_field("press_held", want_res.press_held, got_res.press_held);
                    check_field("reject_total", int'(want_res.rejects),
                                int'(got_res.rejects));
                end
            end
            if (!idling_on) begin
                out_stall = 0;
                m_tready <= 1'b1;
            end else if (out_calm > 0) begin
                out_calm--;
                m_tready <= 1'b1;
            end else if (out_stall > 0) begin
                out_stall--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                out_stall = gap_len() - 1;
                m_tready <= 1'b0;
            end else begin
                if ($urandom_range(0, 49) == 0)
                    out_calm = $urandom_range(20, 80);
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: cycles with no transaction on any port
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // no history yet: failed measurement, then each way a set gets rejected
        push_set(-16384, 1, 16383, 1, 131071, 1, 0);
        push_set(1000, 1, 5000, 0, 95000, 0, 1);
        push_set(1000, 0, 5000, 1, 95000, 0, 1);
        push_set(1000, 0, 5000, 0, 95000, 1, 1);
        push_set(-16384, 0, 5000, 0, 95000, 0, 1);
        push_set(16383, 0, 5000, 0, 95000, 0, 1);
        push_set(1000, 0, 10001, 0, 95000, 0, 1);
        push_set(1000, 0, 16383, 0, 95000, 0, 1);
        push_set(1000, 0, 5000, 0, 0, 0, 1);
        push_set(1000, 0, 5000, 0, 131071, 0, 1);
        wait_drained();

        // a burst of rejects, full speed
        idling_on = 1'b0;
        repeat (40) begin
            int ch;
            ch = $urandom_range(0, 2);
            push_set(int'($signed(TEMP_W'($urandom))), ch == 0, $urandom_range(0, 16383),
                     ch == 1, $urandom_range(0, 131071), ch == 2, 1);
        end
        wait_drained();
        idling_on = 1'b1;

        // first accepted set on the limits, then step checks around it
        push_set(1000, 0, 5000, 1, 95000, 0, 1);
        push_set(6000, 0, 10000, 0, 85000, 0, 1);
        push_set(6300, 0, 10000, 0, 85000, 0, 1);
        push_set(5700, 0, 8500, 0, 85200, 0, 1);
        push_set(5700, 0, 6999, 0, 85401, 0, 1);
        push_set(5600, 1, 8400, 0, 84999, 0, 1);
        push_set(5600, 0, 8400, 0, 85100, 1, 0);
        wait_drained();
        gen_random(150);
        wait_drained();

        // widest window and steps
        write_reg(REG_TEMP_MIN, -16384);
        write_reg(REG_TEMP_MAX, 16383);
        write_reg(REG_PRESS_MIN, 0);
        write_reg(REG_PRESS_MAX, 131071);
        write_reg(REG_TEMP_STEP, 32767);
        write_reg(REG_HUM_STEP, 16383);
        write_reg(REG_PRESS_STEP, 131071);
        end_writes();
        push_set(-16384, 0, 0, 0, 0, 0, 1);
        push_set(16383, 0, 10000, 0, 131071, 0, 1);
        push_set(16383, 0, 16383, 0, 131071, 0, 1);
        gen_random(150);
        wait_drained();

        // zero steps: only a repeat of the last good value passes
        write_reg(REG_TEMP_STEP, 0);
        write_reg(REG_HUM_STEP, 0);
        write_reg(REG_PRESS_STEP, 0);
        end_writes();
        gen_random(150);
        wait_drained();

        // crossed limits, and a write to an index that decodes nothing
        write_reg(REG_TEMP_STEP, 500);
        write_reg(REG_HUM_STEP, 800);
        write_reg(REG_PRESS_STEP, 300);
        write_reg(REG_TEMP_MIN, 100);
        write_reg(REG_TEMP_MAX, -100);
        write_reg(REG_PRESS_MIN, 100000);
        write_reg(REG_PRESS_MAX, 90000);
        write_reg(REG_SPARE, $urandom_range(0, 131071));
        end_writes();
        gen_random(120);
        wait_drained();

        repeat (4) begin
            random_limits();
            gen_random(130);
            wait_drained();
        end

        repeat (6) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
